@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL of the TEA decrypt block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

@@ hw/rtl/tbd_pkg.sv @@
// ----------------------------------------------------------------------------
// tbd_pkg
// Types, constants and helper functions of the TEA block decrypt pipeline.
// ----------------------------------------------------------------------------
package tbd_pkg;

   localparam int ROUND_COUNT     = 32;
   localparam int STAGE_COUNT     = 2 * ROUND_COUNT;
   localparam int WORD_WIDTH      = 32;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [WORD_WIDTH-1:0] TEA_DELTA = 32'h9E37_79B9;

   localparam logic [WORD_WIDTH-1:0] KEY_WORD_0_RESET = 32'h0302_0100;
   localparam logic [WORD_WIDTH-1:0] KEY_WORD_1_RESET = 32'h0706_0504;
   localparam logic [WORD_WIDTH-1:0] KEY_WORD_2_RESET = 32'h0B0A_0908;
   localparam logic [WORD_WIDTH-1:0] KEY_WORD_3_RESET = 32'h0F0E_0D0C;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_KEY_WORD_0,
      CSR_KEY_WORD_1,
      CSR_KEY_WORD_2,
      CSR_KEY_WORD_3
   } csr_index_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] cipher_left;
      logic [WORD_WIDTH-1:0] cipher_right;
   } req_data_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] plain_left;
      logic [WORD_WIDTH-1:0] plain_right;
   } rsp_data_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] left;
      logic [WORD_WIDTH-1:0] right;
   } word_pair_type;

   // Round sum seen by round number "round": delta times the rounds still to go.
   function automatic logic [WORD_WIDTH-1:0] round_sum(input int round);
      logic [WORD_WIDTH-1:0] remaining;
      remaining = WORD_WIDTH'(ROUND_COUNT - round);
      return WORD_WIDTH'(TEA_DELTA * remaining);
   endfunction

   function automatic logic [WORD_WIDTH-1:0] mix_word(
      input logic [WORD_WIDTH-1:0] w,
      input logic [WORD_WIDTH-1:0] sum,
      input logic [WORD_WIDTH-1:0] key_shl,
      input logic [WORD_WIDTH-1:0] key_shr
   );
      logic [WORD_WIDTH-1:0] a;
      logic [WORD_WIDTH-1:0] b;
      logic [WORD_WIDTH-1:0] c;
      a = (w << 4) + key_shl;
      b = w + sum;
      c = (w >> 5) + key_shr;
      return a ^ b ^ c;
   endfunction

endpackage

@@ hw/rtl/tbd_half_round.sv @@
// ----------------------------------------------------------------------------
// tbd_half_round
// One registered half round of TEA decryption: one word is reduced by the
// mix of the other word, the round sum and two key words.
// ----------------------------------------------------------------------------
module tbd_half_round (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  logic                            valid_in,
   input  tbd_pkg::word_pair_type          data_in,
   input  logic [tbd_pkg::WORD_WIDTH-1:0]  round_sum,
   input  logic [tbd_pkg::WORD_WIDTH-1:0]  key_shl,
   input  logic [tbd_pkg::WORD_WIDTH-1:0]  key_shr,
   input  logic                            upd_right,
   output logic                            valid_out,
   output tbd_pkg::word_pair_type          data_out
);

   logic                           valid_ff;
   logic                           valid_in_d;
   tbd_pkg::word_pair_type         data_ff;
   tbd_pkg::word_pair_type         data_in_d;
   logic [tbd_pkg::WORD_WIDTH-1:0] source_word;
   logic [tbd_pkg::WORD_WIDTH-1:0] target_word;
   logic [tbd_pkg::WORD_WIDTH-1:0] new_word;

   always_comb begin
      source_word = upd_right ? data_in.left : data_in.right;
      target_word = upd_right ? data_in.right : data_in.left;
      new_word    = target_word - tbd_pkg::mix_word(source_word, round_sum, key_shl, key_shr);
      data_in_d   = data_in;
      if (upd_right) begin
         data_in_d.right = new_word;
      end else begin
         data_in_d.left = new_word;
      end
      valid_in_d = valid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= valid_in_d;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in_d;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

@@ hw/rtl/tea_block_decrypt.sv @@
// ----------------------------------------------------------------------------
// tea_block_decrypt
// TEA block decryption over a pipeline of one half round per stage.
// Each half round has its own register stage; one block enters per cycle unless
// a result-side stall backs up the pipeline.
// An empty stage fills while a later one waits, so bubbles close under stall.
// Reset clears every stage valid bit and loads the default key words.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tea_block_decrypt (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  tbd_pkg::req_data_type                req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output tbd_pkg::rsp_data_type                rsp_data,
   input  logic                                 csr_write_enable,
   input  logic [tbd_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [tbd_pkg::WORD_WIDTH-1:0]       csr_write_data
);

   logic [tbd_pkg::WORD_WIDTH-1:0] key_word_0_ff;
   logic [tbd_pkg::WORD_WIDTH-1:0] key_word_1_ff;
   logic [tbd_pkg::WORD_WIDTH-1:0] key_word_2_ff;
   logic [tbd_pkg::WORD_WIDTH-1:0] key_word_3_ff;

   logic [tbd_pkg::STAGE_COUNT:0] valid_chain;
   logic [tbd_pkg::STAGE_COUNT:0] load_chain;
   tbd_pkg::word_pair_type        data_chain [tbd_pkg::STAGE_COUNT+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         key_word_0_ff <= tbd_pkg::KEY_WORD_0_RESET;
         key_word_1_ff <= tbd_pkg::KEY_WORD_1_RESET;
         key_word_2_ff <= tbd_pkg::KEY_WORD_2_RESET;
         key_word_3_ff <= tbd_pkg::KEY_WORD_3_RESET;
      end else if (csr_write_enable) begin
         unique case (tbd_pkg::csr_index_type'(csr_index))
            tbd_pkg::CSR_KEY_WORD_0: key_word_0_ff <= csr_write_data;
            tbd_pkg::CSR_KEY_WORD_1: key_word_1_ff <= csr_write_data;
            tbd_pkg::CSR_KEY_WORD_2: key_word_2_ff <= csr_write_data;
            tbd_pkg::CSR_KEY_WORD_3: key_word_3_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign valid_chain[0]      = req_valid;
   assign data_chain[0].left  = req_data.cipher_left;
   assign data_chain[0].right = req_data.cipher_right;

   // A stage may load when it is empty or when the stage after it loads too.
   assign load_chain[tbd_pkg::STAGE_COUNT] = !rsp_stall;

   for (genvar i = 0; i < tbd_pkg::STAGE_COUNT; i++) begin : g_stage
      localparam bit UpdRight = (i % 2) == 0;

      assign load_chain[i] = !valid_chain[i+1] || load_chain[i+1];

      // Even stages update the right word from the left, odd stages the reverse.
      tbd_half_round u_half_round (
         .clock     (clock),
         .reset     (reset),
         .load      (load_chain[i]),
         .valid_in  (valid_chain[i]),
         .data_in   (data_chain[i]),
         .round_sum (tbd_pkg::round_sum(i / 2)),
         .key_shl   (UpdRight ? key_word_2_ff : key_word_0_ff),
         .key_shr   (UpdRight ? key_word_3_ff : key_word_1_ff),
         .upd_right (UpdRight),
         .valid_out (valid_chain[i+1]),
         .data_out  (data_chain[i+1])
      );
   end

   assign req_stall            = !load_chain[0];
   assign rsp_valid            = valid_chain[tbd_pkg::STAGE_COUNT];
   assign rsp_data.plain_left  = data_chain[tbd_pkg::STAGE_COUNT].left;
   assign rsp_data.plain_right = data_chain[tbd_pkg::STAGE_COUNT].right;

   // An accepted transaction always lands in the first stage.
   `ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && !req_stall, valid_chain[1])

   // With every stage full and the result held back, no new transaction enters.
   `ASSERT_IMPLIES(a_full_stalls, clock, reset, (&valid_chain[tbd_pkg::STAGE_COUNT:1]) && rsp_stall, req_stall)

   // The cycle after reset the pipeline holds no result.
   `ASSERT_IMPLIES(a_reset_empty, clock, reset, $past(reset), !rsp_valid)

endmodule

@@ bench/tea_decrypt_checker.sv @@
// ----------------------------------------------------------------------------
// tea_decrypt_checker
// Watches the block, key and plaintext channels of the TEA block decrypt
// pipeline. It keeps its own copy of the key words, decrypts every accepted
// block, queues the plaintext it predicts and compares each accepted result
// against the oldest prediction, one word at a time.
// ----------------------------------------------------------------------------
module tea_decrypt_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  tbd_pkg::req_data_type                req_data,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  tbd_pkg::rsp_data_type                rsp_data,
   input  logic                                 csr_write_enable,
   input  logic [tbd_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [tbd_pkg::WORD_WIDTH-1:0]       csr_write_data,
   output int                                   error_count,
   output int                                   pending_count,
   output int                                   checked_count
);

   import tbd_pkg::*;

   localparam int EXPECT_DEPTH = 256;

   logic [WORD_WIDTH-1:0] key_word [4];
   rsp_data_type          expected_plain [EXPECT_DEPTH];
   int                    expect_head = 0;
   int                    expect_tail = 0;
   int                    errors  = 0;
   int                    pending = 0;
   int                    checked = 0;

   assign error_count   = errors;
   assign pending_count = pending;
   assign checked_count = checked;

   task automatic report_error(input string message);
      $display("mismatch: %s", message);
      errors++;
   endtask

   // Full 32-round TEA decryption of one block under the current key words.
   function automatic rsp_data_type decrypt_block(input req_data_type block);
      logic [WORD_WIDTH-1:0] left;
      logic [WORD_WIDTH-1:0] right;
      logic [WORD_WIDTH-1:0] sum;
      rsp_data_type          plain;
      left  = block.cipher_left;
      right = block.cipher_right;
      sum   = WORD_WIDTH'(TEA_DELTA * ROUND_COUNT);
      for (int r = 0; r < ROUND_COUNT; r++) begin
         right = right - (((left << 4) + key_word[CSR_KEY_WORD_2]) ^ (left + sum)
                          ^ ((left >> 5) + key_word[CSR_KEY_WORD_3]));
         left  = left - (((right << 4) + key_word[CSR_KEY_WORD_0]) ^ (right + sum)
                         ^ ((right >> 5) + key_word[CSR_KEY_WORD_1]));
         sum   = sum - TEA_DELTA;
      end
      plain.plain_left  = left;
      plain.plain_right = right;
      return plain;
   endfunction

   always @(posedge clock) begin
      rsp_data_type want;
      if (reset) begin
         expect_head = 0;
         expect_tail = 0;
         key_word[CSR_KEY_WORD_0] = KEY_WORD_0_RESET;
         key_word[CSR_KEY_WORD_1] = KEY_WORD_1_RESET;
         key_word[CSR_KEY_WORD_2] = KEY_WORD_2_RESET;
         key_word[CSR_KEY_WORD_3] = KEY_WORD_3_RESET;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expect_tail == expect_head) begin
               report_error($sformatf("result %08h %08h with no block outstanding",
                                      rsp_data.plain_left, rsp_data.plain_right));
            end else begin
               want = expected_plain[expect_head % EXPECT_DEPTH];
               expect_head++;
               checked++;
               if (rsp_data.plain_left !== want.plain_left)
                  report_error($sformatf("plain_left expected %08h, got %08h",
                                         want.plain_left, rsp_data.plain_left));
               if (rsp_data.plain_right !== want.plain_right)
                  report_error($sformatf("plain_right expected %08h, got %08h",
                                         want.plain_right, rsp_data.plain_right));
            end
         end
         if (req_valid && !req_stall) begin
            if (expect_tail - expect_head == EXPECT_DEPTH) begin
               report_error("more blocks outstanding than the prediction buffer holds");
            end else begin
               expected_plain[expect_tail % EXPECT_DEPTH] = decrypt_block(req_data);
               expect_tail++;
            end
         end
         // Key writes only happen while the pipeline is empty.
         if (csr_write_enable)
            key_word[csr_index] = csr_write_data;
      end
      pending = expect_tail - expect_head;
   end

endmodule

@@ bench/tb_tea_block_decrypt.sv @@
// ----------------------------------------------------------------------------
// tb_tea_block_decrypt
// Drives ciphertext blocks and key settings into the TEA block decrypt
// pipeline with random gaps and result-side stalls, and gives the verdict
// from the failure count of the checker that runs beside the block.
// ----------------------------------------------------------------------------
module tb_tea_block_decrypt;

   import tbd_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PHASES  = 5;
   localparam int PHASE_BLOCKS   = 100;

   logic                          clock            = 1'b0;
   logic                          reset            = 1'b1;
   logic                          req_valid        = 1'b0;
   logic                          req_stall;
   req_data_type                  req_data         = '0;
   logic                          rsp_valid;
   logic                          rsp_stall        = 1'b0;
   rsp_data_type                  rsp_data;
   logic                          csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]    csr_index        = '0;
   logic [WORD_WIDTH-1:0]         csr_write_data   = '0;

   int   error_count;
   int   pending_count;
   int   checked_count;
   int   blocks_sent  = 0;
   int   key_settings = 1;
   int   quiet_cycles = 0;
   bit   req_burst    = 1'b0;
   bit   rsp_burst    = 1'b0;

   tea_block_decrypt u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   tea_decrypt_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .error_count      (error_count),
      .pending_count    (pending_count),
      .checked_count    (checked_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Words biased toward the edges of the 32-bit range.
   function automatic logic [WORD_WIDTH-1:0] pick_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return 32'h8000_0000;
         3: return 32'h0000_0001;
         default: return $urandom;
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_block(input logic [WORD_WIDTH-1:0] left,
                             input logic [WORD_WIDTH-1:0] right);
      int gap;
      if ($urandom_range(0, 31) == 0)
         req_burst = !req_burst;
      gap = req_burst ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{cipher_left: left, cipher_right: right};
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
      blocks_sent++;
   endtask

   // Stops the block stream and waits until every plaintext has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
   endtask

   task automatic load_key(input logic [WORD_WIDTH-1:0] key [4]);
      foreach (key[i]) begin
         csr_write_enable <= 1'b1;
         csr_index        <= csr_index_type'(i);
         csr_write_data   <= key[i];
         @(negedge clock);
      end
      csr_write_enable <= 1'b0;
      key_settings++;
   endtask

   // Result side: a random stall before each transaction, with stall-free stretches.
   initial begin
      int hold;
      while (reset)
         @(negedge clock);
      forever begin
         if ($urandom_range(0, 31) == 0)
            rsp_burst = !rsp_burst;
         hold = rsp_burst ? 0 : $urandom_range(0, 19);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [WORD_WIDTH-1:0] key [4];
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Edge values under the key loaded at reset.
      send_block('0, '0);
      send_block('1, '1);
      send_block('0, '1);
      send_block('1, '0);
      send_block(32'h8000_0000, 32'h0000_0001);
      send_block(32'h0000_0001, 32'h8000_0000);
      send_block(32'hAAAA_AAAA, 32'h5555_5555);
      send_block(32'h5555_5555, 32'hAAAA_AAAA);
      drain();

      key = '{'0, '0, '0, '0};
      load_key(key);
      send_block('0, '0);
      send_block('1, '1);
      send_block(32'h0123_4567, 32'h89AB_CDEF);
      send_block(32'h8000_0000, 32'h8000_0000);
      drain();

      key = '{'1, '1, '1, '1};
      load_key(key);
      send_block('0, '0);
      send_block('1, '1);
      send_block(32'hFEDC_BA98, 32'h7654_3210);
      send_block(32'h0000_0001, 32'h0000_0001);
      drain();

      key = '{32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000, 32'h0000_0001};
      load_key(key);
      send_block('1, '0);
      send_block(32'hDEAD_BEEF, 32'h0BAD_F00D);
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         foreach (key[i])
            key[i] = pick_word();
         load_key(key);
         repeat (PHASE_BLOCKS)
            send_block(pick_word(), pick_word());
         drain();
      end

      repeat (STAGE_COUNT + 8) @(negedge clock);
      $display("sent %0d ciphertext blocks under %0d key settings, %0d plaintexts compared",
               blocks_sent, key_settings, checked_count);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", error_count);
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/tbd_pkg.sv
hw/rtl/tbd_half_round.sv
hw/rtl/tea_block_decrypt.sv
bench/tea_decrypt_checker.sv
bench/tb_tea_block_decrypt.sv
